// File: rtl/core/bqid_pkg.sv
// Package for the bounded queue insert/delete unit: shared types and codes.
// No dependencies; imported by bqid_ctrl, bqid_dp and the top level.
package bqid_pkg;

    localparam int CNT_W = 5;   // entry count, limit and size fields
    localparam int POS_W = 8;   // request index
    localparam int IN_W  = 32;  // word as it arrives on the input port

    localparam logic [CNT_W-1:0] LIMIT_RST = 5'd16;

    typedef enum logic [1:0] {
        FN_APPEND     = 2'd0,
        FN_PUSH_FRONT = 2'd1,
        FN_INSERT     = 2'd2,
        FN_DELETE     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_TAIL_DROPPED = 2'd1,
        ST_DISCARDED    = 2'd2,
        ST_BAD_INDEX    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_PLACE  = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic             load;   // latch the incoming word
        t_op              op;
        logic [POS_W-1:0] pos;
        logic             grow;   // place adds an entry (else tail is dropped)
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } t_dp_stat;

endpackage

// File: rtl/core/bqid_dp.sv
// Datapath: row of storage cells with per-cell shift select, and the entry count.
// Depends on bqid_pkg; driven by bqid_ctrl commands.
module bqid_dp #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bqid_pkg::t_cmd        i_cmd,
    input  logic [bqid_pkg::IN_W-1:0] i_word,
    output bqid_pkg::t_dp_stat    o_stat
);
    import bqid_pkg::*;

    // the 5-bit limit caps the count at 31, so no more cells are ever used
    localparam int CELLS = (DEPTH < 31) ? DEPTH : 31;

    logic [WIDTH-1:0] r_cell [CELLS];
    logic [WIDTH-1:0] n_cell [CELLS];
    logic [WIDTH-1:0] r_word;
    logic [WIDTH-1:0] w_word_in;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] w_last;

    generate
        if (WIDTH <= IN_W) begin : g_trunc
            assign w_word_in = i_word[WIDTH-1:0];
        end else begin : g_ext
            assign w_word_in = {{(WIDTH-IN_W){1'b0}}, i_word};
        end
    endgenerate

    assign w_last = r_count + {{(CNT_W-1){1'b0}}, i_cmd.grow};

    always_comb begin
        for (int i = 0; i < CELLS; i++) begin
            n_cell[i] = r_cell[i];
            unique case (i_cmd.op)
                OP_PLACE: begin
                    if (POS_W'(i) == i_cmd.pos) begin
                        n_cell[i] = r_word;
                    end else if (POS_W'(i) > i_cmd.pos && CNT_W'(i) < w_last) begin
                        n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                    end
                end
                OP_DELETE: begin
                    if (POS_W'(i) >= i_cmd.pos && CNT_W'(i + 1) < r_count) begin
                        n_cell[i] = r_cell[(i + 1 < CELLS) ? i + 1 : i];
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.op == OP_PLACE && i_cmd.grow) begin
            n_count = r_count + 5'd1;
        end else if (i_cmd.op == OP_DELETE) begin
            n_count = r_count - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= w_word_in;
        end
        for (int i = 0; i < CELLS; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    assign o_stat.count = r_count;

endmodule

// File: rtl/core/bqid_ctrl.sv
// Controller: request handshake, operation decode and result register.
// Depends on bqid_pkg; issues commands to bqid_dp and reads its count.
module bqid_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_func,
    input  logic [bqid_pkg::POS_W-1:0] i_position,
    input  logic                       i_position_unknown,
    input  logic [bqid_pkg::CNT_W-1:0] i_queue_limit,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [bqid_pkg::CNT_W-1:0] o_size_after,
    output logic                       o_shape_changed,
    output bqid_pkg::t_cmd             o_cmd,
    input  bqid_pkg::t_dp_stat         i_stat
);
    import bqid_pkg::*;

    localparam int CELLS = (DEPTH < 31) ? DEPTH : 31;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state           r_state;
    t_func            r_func;
    logic [POS_W-1:0] r_pos;
    logic             r_unk;
    logic             r_out_valid;
    t_status          r_status;
    logic [CNT_W-1:0] r_size;
    logic             r_changed;

    logic             w_in_acc;
    logic [CNT_W-1:0] w_lim;
    logic [POS_W-1:0] w_cnt8;
    logic             w_full;
    t_op              w_op;
    logic [POS_W-1:0] w_pos;
    t_status          w_st;
    logic [CNT_W-1:0] w_new_cnt;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_lim  = (i_queue_limit > CNT_W'(CELLS)) ? CNT_W'(CELLS) : i_queue_limit;
    assign w_cnt8 = {{(POS_W-CNT_W){1'b0}}, i_stat.count};
    assign w_full = i_stat.count >= w_lim;

    always_comb begin
        w_op  = OP_NONE;
        w_pos = r_pos;
        w_st  = ST_DONE;
        unique case (r_func)
            FN_APPEND: begin
                if (w_full) begin
                    w_st = ST_DISCARDED;
                end else begin
                    w_op  = OP_PLACE;
                    w_pos = w_cnt8;
                end
            end
            FN_PUSH_FRONT: begin
                if (w_lim == '0) begin
                    w_st = ST_DISCARDED;
                end else begin
                    w_op  = OP_PLACE;
                    w_pos = '0;
                    w_st  = w_full ? ST_TAIL_DROPPED : ST_DONE;
                end
            end
            FN_INSERT: begin
                if (r_unk || r_pos > w_cnt8) begin
                    w_st = ST_BAD_INDEX;
                end else if (w_lim == '0 || (w_full && r_pos == w_cnt8)) begin
                    w_st = ST_DISCARDED;
                end else begin
                    w_op = OP_PLACE;
                    w_st = w_full ? ST_TAIL_DROPPED : ST_DONE;
                end
            end
            FN_DELETE: begin
                if (r_unk || r_pos >= w_cnt8) begin
                    w_st = ST_BAD_INDEX;
                end else begin
                    w_op = OP_DELETE;
                end
            end
        endcase
        if (w_op == OP_PLACE && !w_full) begin
            w_new_cnt = i_stat.count + 5'd1;
        end else if (w_op == OP_DELETE) begin
            w_new_cnt = i_stat.count - 5'd1;
        end else begin
            w_new_cnt = i_stat.count;
        end
    end

    always_comb begin
        o_cmd.load = w_in_acc;
        o_cmd.op   = (r_state == S_EXEC) ? w_op : OP_NONE;
        o_cmd.pos  = w_pos;
        o_cmd.grow = !w_full;
    end

    // result register is always empty in S_EXEC: the accept edge either found it
    // empty or emptied it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_func      <= FN_APPEND;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (w_in_acc) begin
                        r_state <= S_EXEC;
                        r_func  <= t_func'(i_func);
                        r_pos   <= i_position;
                        r_unk   <= i_position_unknown;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    r_status    <= w_st;
                    r_size      <= w_new_cnt;
                    r_changed   <= (w_new_cnt != i_stat.count);
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_size_after    = r_size;
    assign o_shape_changed = r_changed;

`ifndef SYNTHESIS
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_EXEC)
        else $error("accepted item not executed next cycle");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without an execute cycle");

    a_change_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_changed) |-> r_status == ST_DONE)
        else $error("size changed on a request that did not complete");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_op == OP_PLACE && !w_full) |-> i_stat.count < w_lim)
        else $error("entry added past the limit");
`endif

endmodule

// File: rtl/core/bounded_queue_insert_delete_unit.sv
// Bounded queue with push back/front and indexed insert/delete. An item is
// taken, then executed in the next cycle, where every storage cell picks its
// new word (keep, shift, or the new word) at once; the result is registered
// at that edge. The controller's accept/execute sequence takes no new item
// while one is executing, and the next item can be taken in the cycle the
// result appears if the result is taken then. Storage is min(DEPTH, 31)
// cells, since the 5-bit limit never lets more entries in. Entries that
// were never written hold no defined value.
// Depends on bqid_pkg, bqid_ctrl and bqid_dp.
module bounded_queue_insert_delete_unit #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_position,
    input  logic        i_position_unknown,
    input  logic [31:0] i_element_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_size_after,
    output logic        o_shape_changed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bqid_pkg::*;

    logic [CNT_W-1:0] r_queue_limit;
    t_cmd             w_cmd;
    t_dp_stat         w_stat;

    assign pready = 1'b1;

    // single register, decoded at addresses 0 to 3 (paddr[2] low)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= LIMIT_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_queue_limit <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, r_queue_limit};

    bqid_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_func             (i_func),
        .i_position         (i_position),
        .i_position_unknown (i_position_unknown),
        .i_queue_limit      (r_queue_limit),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_size_after       (o_size_after),
        .o_shape_changed    (o_shape_changed),
        .o_cmd              (w_cmd),
        .i_stat             (w_stat)
    );

    bqid_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_word  (i_element_value),
        .o_stat  (w_stat)
    );

endmodule
